>>> src/pcl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pcl_pkg;

  // Curve table geometry
  localparam int TABLE_DEPTH = 512;
  localparam int TBL_AW      = $clog2(TABLE_DEPTH);

  // Field widths
  localparam int PIX_W   = 8;
  localparam int IDX_W   = 9;
  localparam int ENTRY_W = 16;

  // Stream packing
  localparam int IN_FIELDS_W = 4 * PIX_W + IDX_W + ENTRY_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 4 * PIX_W;
  localparam int OFS_RED     = 0;
  localparam int OFS_GREEN   = OFS_RED + PIX_W;
  localparam int OFS_BLUE    = OFS_GREEN + PIX_W;
  localparam int OFS_ALPHA   = OFS_BLUE + PIX_W;
  localparam int OFS_IDX     = OFS_ALPHA + PIX_W;
  localparam int OFS_VAL     = OFS_IDX + IDX_W;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LUMA_FORMULA = 1'd1;

  // Opcodes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef enum logic [2:0] {
    MODE_RED   = 3'd0,
    MODE_GREEN = 3'd1,
    MODE_BLUE  = 3'd2,
    MODE_ALPHA = 3'd3,
    MODE_LUMA  = 3'd4,
    MODE_RGB   = 3'd5,
    MODE_HUE   = 3'd6,
    MODE_SAT   = 3'd7
  } mode_t;

  // Luma weights, Q0.16
  localparam logic [15:0] W709_R = 16'd13933;
  localparam logic [15:0] W709_G = 16'd46871;
  localparam logic [15:0] W709_B = 16'd4732;
  localparam logic [15:0] W601_R = 16'd19595;
  localparam logic [15:0] W601_G = 16'd38470;
  localparam logic [15:0] W601_B = 16'd7471;
  localparam logic [24:0] LUMA_RND = 25'd32768;

  // Hue sector bases in degrees
  localparam logic [8:0] DEG_0   = 9'd0;
  localparam logic [8:0] DEG_120 = 9'd120;
  localparam logic [8:0] DEG_240 = 9'd240;
  localparam logic [8:0] DEG_360 = 9'd360;
  localparam logic [13:0] DEG_60 = 14'd60;

  // Entry limits: 360 degrees in Q9.7, 1.0 in Q1.15
  localparam logic [ENTRY_W-1:0] HUE_MAX = 16'd46080;
  localparam logic [ENTRY_W-1:0] SAT_ONE = 16'd32768;
  localparam logic [ENTRY_W-1:0] BYTE_MAX = 16'd255;

  // floor(n / 15) = (n * RECIP15) >> RECIP15_SH for n < 2^23
  localparam logic [23:0] RECIP15    = 24'd8947849;
  localparam int          RECIP15_SH = 27;

  // Restoring divider geometry
  localparam int DIV_NUM_W  = 32;
  localparam int DIV_DEN_W  = 8;
  localparam int DIV_STEP   = 4;
  localparam int DIV_STAGES = DIV_NUM_W / DIV_STEP;

endpackage

`default_nettype wire

>>> src/pixel_curve_lut_mapper.sv
`timescale 1ns / 1ps
`default_nettype none

// A pixel transaction passes input, front, 8 divider stages, address, table read, two
// multiply stages and output before it shows on out_*.
// Throughput: one transaction per cycle; the whole pipe holds only while the output
// register is full and out_tready is low. Table writes give no result.
// Reset (rst_n low, synchronous): clears all valid bits and the table-loaded flag, sets
// channel_mode to rgb and luma_formula to Rec.709; table contents are undefined.

module pixel_curve_lut_mapper (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // red, green, blue, alpha, entry_index, entry_value, zero fill
  input  wire logic [pcl_pkg::IN_TDATA_W-1:0]    in_tdata,
  // opcode
  input  wire logic [pcl_pkg::IN_TUSER_W-1:0]    in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // out_red, out_green, out_blue, out_alpha
  output logic      [pcl_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  wire logic                              cfg_wr_en,
  input  wire logic [pcl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [pcl_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import pcl_pkg::*;

  typedef struct packed {
    logic               op;
    logic [PIX_W-1:0]   red;
    logic [PIX_W-1:0]   green;
    logic [PIX_W-1:0]   blue;
    logic [PIX_W-1:0]   alpha;
    logic [IDX_W-1:0]   idx;
    logic [ENTRY_W-1:0] val;
  } pay_t;

  typedef struct packed {
    pay_t             pay;
    logic [PIX_W-1:0] mx;
    logic             grey;
    logic [8:0]       base;
    logic             hpos;
    logic [PIX_W-1:0] luma;
  } dly_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  mode_t mode_r;
  logic  luma709_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_RGB;
      luma709_r <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_CHANNEL_MODE: mode_r    <= mode_t'(cfg_wdata);
        CFG_LUMA_FORMULA: luma709_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Whole pipe advances together; the output register parts it from the sink.
  logic en;
  logic out_vld_r;
  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;

  // ---------------------------------------------------------------------------
  // Stage A: input register
  // ---------------------------------------------------------------------------
  logic a_vld_r;
  pay_t a_pay_r, a_pay_nxt;

  always_comb begin
    a_pay_nxt.op    = in_tuser[0];
    a_pay_nxt.red   = in_tdata[OFS_RED +: PIX_W];
    a_pay_nxt.green = in_tdata[OFS_GREEN +: PIX_W];
    a_pay_nxt.blue  = in_tdata[OFS_BLUE +: PIX_W];
    a_pay_nxt.alpha = in_tdata[OFS_ALPHA +: PIX_W];
    a_pay_nxt.idx   = in_tdata[OFS_IDX +: IDX_W];
    a_pay_nxt.val   = in_tdata[OFS_VAL +: ENTRY_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_pay_r <= a_pay_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: max/min, hue sector, luma weight products
  // ---------------------------------------------------------------------------
  logic             b_vld_r;
  pay_t             b_pay_r;
  logic [PIX_W-1:0] b_mx_r, b_mx_nxt, b_delta_r, b_delta_nxt;
  logic             b_grey_r, b_hpos_r, b_hpos_nxt;
  logic [8:0]       b_base_r, b_base_nxt;
  logic [13:0]      b_h60_r, b_h60_nxt;
  logic [23:0]      b_prod_r [3];
  logic [23:0]      b_prod_nxt [3];

  always_comb begin
    logic [PIX_W-1:0] mn, hi, lo, diff;
    logic [15:0]      wr, wg, wb;
    b_mx_nxt = a_pay_r.red;
    mn       = a_pay_r.red;
    if (a_pay_r.green > b_mx_nxt) b_mx_nxt = a_pay_r.green;
    if (a_pay_r.blue > b_mx_nxt)  b_mx_nxt = a_pay_r.blue;
    if (a_pay_r.green < mn)       mn = a_pay_r.green;
    if (a_pay_r.blue < mn)        mn = a_pay_r.blue;
    b_delta_nxt = b_mx_nxt - mn;
    // Pick the dominant channel and the pair that sets the hue offset
    if (a_pay_r.red == b_mx_nxt) begin
      b_base_nxt = DEG_0;
      hi         = a_pay_r.green;
      lo         = a_pay_r.blue;
    end else if (a_pay_r.green == b_mx_nxt) begin
      b_base_nxt = DEG_120;
      hi         = a_pay_r.blue;
      lo         = a_pay_r.red;
    end else begin
      b_base_nxt = DEG_240;
      hi         = a_pay_r.red;
      lo         = a_pay_r.green;
    end
    b_hpos_nxt = (hi >= lo);
    diff       = b_hpos_nxt ? (hi - lo) : (lo - hi);
    b_h60_nxt  = 14'({6'd0, diff} * DEG_60);
    wr = luma709_r ? W709_R : W601_R;
    wg = luma709_r ? W709_G : W601_G;
    wb = luma709_r ? W709_B : W601_B;
    b_prod_nxt[0] = 24'(wr) * 24'(a_pay_r.red);
    b_prod_nxt[1] = 24'(wg) * 24'(a_pay_r.green);
    b_prod_nxt[2] = 24'(wb) * 24'(a_pay_r.blue);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_pay_r   <= a_pay_r;
      b_mx_r    <= b_mx_nxt;
      b_delta_r <= b_delta_nxt;
      b_grey_r  <= (b_delta_nxt == '0);
      b_base_r  <= b_base_nxt;
      b_hpos_r  <= b_hpos_nxt;
      b_h60_r   <= b_h60_nxt;
      b_prod_r  <= b_prod_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Divider stages: saturation = (delta << 16) / max,
  // hue offset = (60 * (hi - lo) << 16) / delta. Payload rides alongside.
  // ---------------------------------------------------------------------------
  logic [DIV_NUM_W-1:0] qs, qh;

  pcl_div u_div_sat (
    .clk (clk),
    .en  (en),
    .num ({8'd0, b_delta_r, 16'd0}),
    .den (b_mx_r),
    .quo (qs)
  );

  pcl_div u_div_hue (
    .clk (clk),
    .en  (en),
    .num ({2'd0, b_h60_r, 16'd0}),
    .den (b_delta_r),
    .quo (qh)
  );

  logic d_vld_r [DIV_STAGES];
  dly_t d_r     [DIV_STAGES];
  dly_t d0_nxt;

  always_comb begin
    logic [24:0] sum;
    sum = 25'(b_prod_r[0]) + 25'(b_prod_r[1]) + 25'(b_prod_r[2]) + LUMA_RND;
    d0_nxt.pay  = b_pay_r;
    d0_nxt.mx   = b_mx_r;
    d0_nxt.grey = b_grey_r;
    d0_nxt.base = b_base_r;
    d0_nxt.hpos = b_hpos_r;
    d0_nxt.luma = sum[23:16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_STAGES; k++) d_vld_r[k] <= 1'b0;
    end else if (en) begin
      d_vld_r[0] <= b_vld_r;
      for (int k = 1; k < DIV_STAGES; k++) d_vld_r[k] <= d_vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r[0] <= d0_nxt;
      for (int k = 1; k < DIV_STAGES; k++) d_r[k] <= d_r[k-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage E: assemble hue (Q16 degrees) and saturation (Q1.16)
  // ---------------------------------------------------------------------------
  dly_t        dl;
  logic        e_vld_r;
  dly_t        e_d_r;
  logic [24:0] e_deg_r, e_deg_nxt;
  logic [16:0] e_s_r, e_s_nxt;

  assign dl = d_r[DIV_STAGES-1];

  always_comb begin
    logic [8:0] base_neg;
    base_neg = (dl.base == DEG_0) ? DEG_360 : dl.base;
    if (dl.grey) begin
      e_deg_nxt = '0;
      e_s_nxt   = '0;
    end else begin
      e_deg_nxt = dl.hpos ? ({dl.base, 16'd0} + qh[24:0])
                          : ({base_neg, 16'd0} - qh[24:0]);
      e_s_nxt   = qs[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else if (en) begin
      e_vld_r <= d_vld_r[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_d_r   <= dl;
      e_deg_r <= e_deg_nxt;
      e_s_r   <= e_s_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Curve table: three copies written alike, one read port each, so rgb mode
  // reads all three channels at once. Writes land at this stage, in
  // stream order with the pixel reads.
  // ---------------------------------------------------------------------------
  logic [TBL_AW-1:0]  raddr0;
  logic [24:0]        sat_prod;
  logic               tbl_we;
  logic               tbl_ready_r;
  logic [ENTRY_W-1:0] rd0, rd1, rd2;

  always_comb begin
    sat_prod = ({8'd0, e_s_r} << 8) - {8'd0, e_s_r};
    unique case (mode_r)
      MODE_RED:   raddr0 = TBL_AW'(e_d_r.pay.red);
      MODE_GREEN: raddr0 = TBL_AW'(e_d_r.pay.green);
      MODE_BLUE:  raddr0 = TBL_AW'(e_d_r.pay.blue);
      MODE_ALPHA: raddr0 = TBL_AW'(e_d_r.pay.alpha);
      MODE_LUMA:  raddr0 = TBL_AW'(e_d_r.luma);
      MODE_RGB:   raddr0 = TBL_AW'(e_d_r.pay.red);
      MODE_HUE:   raddr0 = TBL_AW'(e_deg_r[24:16]);
      MODE_SAT:   raddr0 = TBL_AW'(sat_prod[24:16]);
      default:    raddr0 = TBL_AW'(e_d_r.pay.red);
    endcase
  end

  // Write the table as a write transaction advances here; the 9-bit index never exceeds the table
  assign tbl_we = en && e_vld_r && (e_d_r.pay.op == OP_WRITE)
               && (int'(e_d_r.pay.idx) < TABLE_DEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbl_ready_r <= 1'b0;
    end else if (tbl_we) begin
      tbl_ready_r <= 1'b1;
    end
  end

  pcl_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_tbl0 (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (TBL_AW'(e_d_r.pay.idx)),
    .wdata (e_d_r.pay.val),
    .re    (en),
    .raddr (raddr0),
    .rdata (rd0)
  );

  pcl_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_tbl1 (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (TBL_AW'(e_d_r.pay.idx)),
    .wdata (e_d_r.pay.val),
    .re    (en),
    .raddr (TBL_AW'(e_d_r.pay.green)),
    .rdata (rd1)
  );

  pcl_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_tbl2 (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (TBL_AW'(e_d_r.pay.idx)),
    .wdata (e_d_r.pay.val),
    .re    (en),
    .raddr (TBL_AW'(e_d_r.pay.blue)),
    .rdata (rd2)
  );

  // ---------------------------------------------------------------------------
  // Stage F: table data arrives. Pixels only from here on.
  // ---------------------------------------------------------------------------
  logic        f_vld_r, f_rdy_r;
  dly_t        f_d_r;
  logic [24:0] f_deg_r;
  logic [16:0] f_s_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (en) begin
      f_vld_r <= e_vld_r && (e_d_r.pay.op == OP_PIXEL);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_rdy_r <= tbl_ready_r;
      f_d_r   <= e_d_r;
      f_deg_r <= e_deg_r;
      f_s_r   <= e_s_r;
    end
  end

  // Saturate bytes, form luma gain products, scale hue to sixths
  logic [PIX_W-1:0] bsat_nxt [3];
  logic [23:0]      lprod_nxt [3];
  logic [18:0]      hsec_nxt;
  logic [16:0]      ss_nxt;

  always_comb begin
    logic [ENTRY_W-1:0] eh, es;
    logic [22:0]        n;
    logic [46:0]        nq;
    bsat_nxt[0] = (rd0 > BYTE_MAX) ? 8'hFF : rd0[7:0];
    bsat_nxt[1] = (rd1 > BYTE_MAX) ? 8'hFF : rd1[7:0];
    bsat_nxt[2] = (rd2 > BYTE_MAX) ? 8'hFF : rd2[7:0];
    lprod_nxt[0] = 24'(f_d_r.pay.red)   * 24'(rd0);
    lprod_nxt[1] = 24'(f_d_r.pay.green) * 24'(rd0);
    lprod_nxt[2] = 24'(f_d_r.pay.blue)  * 24'(rd0);
    eh = (rd0 > HUE_MAX) ? HUE_MAX : rd0;
    es = (rd0 > SAT_ONE) ? SAT_ONE : rd0;
    // (e << 9) / 60 == (e << 7) / 15 and deg / 60 == (deg >> 2) / 15
    n  = (mode_r == MODE_HUE) ? {eh, 7'd0} : f_deg_r[24:2];
    nq = 47'(n) * 47'(RECIP15);
    hsec_nxt = 19'(nq >> RECIP15_SH);
    ss_nxt   = (mode_r == MODE_HUE) ? f_s_r : {es, 1'b0};
  end

  // ---------------------------------------------------------------------------
  // Stage G: luma results, s*f products
  // ---------------------------------------------------------------------------
  logic             g_vld_r, g_rdy_r;
  dly_t             g_d_r;
  logic [PIX_W-1:0] g_bsat_r [3];
  logic [23:0]      g_lprod_r [3];
  logic [PIX_W-1:0] g_gain_hi_r;
  logic [18:0]      g_hsec_r;
  logic [16:0]      g_ss_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_vld_r <= 1'b0;
    end else if (en) begin
      g_vld_r <= f_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_rdy_r     <= f_rdy_r;
      g_d_r       <= f_d_r;
      g_bsat_r    <= bsat_nxt;
      g_lprod_r   <= lprod_nxt;
      g_gain_hi_r <= rd0[15:8];
      g_hsec_r    <= hsec_nxt;
      g_ss_r      <= ss_nxt;
    end
  end

  logic [PIX_W-1:0] lres_nxt [3];
  logic [16:0]      xp_nxt, xq_nxt, xt_nxt;

  always_comb begin
    logic [15:0] f;
    logic [16:0] nf;
    logic [33:0] sf, snf;
    for (int c = 0; c < 3; c++) begin
      if (g_d_r.luma == '0) begin
        lres_nxt[c] = g_gain_hi_r;
      end else begin
        lres_nxt[c] = (g_lprod_r[c][23:8] > BYTE_MAX) ? 8'hFF : g_lprod_r[c][15:8];
      end
    end
    f   = g_hsec_r[15:0];
    nf  = 17'h10000 - {1'b0, f};
    sf  = 34'(g_ss_r) * 34'(f);
    snf = 34'(g_ss_r) * 34'(nf);
    xp_nxt = 17'(18'h10000 - {1'b0, g_ss_r});
    xq_nxt = 17'(18'h10000 - 18'(sf >> 16));
    xt_nxt = 17'(18'h10000 - 18'(snf >> 16));
  end

  // ---------------------------------------------------------------------------
  // Stage H: p, q, t products and output select
  // ---------------------------------------------------------------------------
  logic             h_vld_r, h_rdy_r;
  dly_t             h_d_r;
  logic [PIX_W-1:0] h_bsat_r [3];
  logic [PIX_W-1:0] h_lres_r [3];
  logic [2:0]       h_sector_r;
  logic [16:0]      h_xp_r, h_xq_r, h_xt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_vld_r <= 1'b0;
    end else if (en) begin
      h_vld_r <= g_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_rdy_r    <= g_rdy_r;
      h_d_r      <= g_d_r;
      h_bsat_r   <= g_bsat_r;
      h_lres_r   <= lres_nxt;
      h_sector_r <= g_hsec_r[18:16];
      h_xp_r     <= xp_nxt;
      h_xq_r     <= xq_nxt;
      h_xt_r     <= xt_nxt;
    end
  end

  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  always_comb begin
    logic [24:0]      pp, qq, tt;
    logic [PIX_W-1:0] v, p, q, t, r_o, g_o, b_o, a_o, hr, hg, hb;
    v  = h_d_r.mx;
    pp = 25'(v) * 25'(h_xp_r);
    qq = 25'(v) * 25'(h_xq_r);
    tt = 25'(v) * 25'(h_xt_r);
    p  = pp[23:16];
    q  = qq[23:16];
    t  = tt[23:16];
    // A remapped hue of a full turn lands in sector six and wraps to zero
    case (h_sector_r)
      3'd1:    begin hr = q; hg = v; hb = p; end
      3'd2:    begin hr = p; hg = v; hb = t; end
      3'd3:    begin hr = p; hg = q; hb = v; end
      3'd4:    begin hr = t; hg = p; hb = v; end
      3'd5:    begin hr = v; hg = p; hb = q; end
      default: begin hr = v; hg = t; hb = p; end
    endcase
    r_o = h_d_r.pay.red;
    g_o = h_d_r.pay.green;
    b_o = h_d_r.pay.blue;
    a_o = h_d_r.pay.alpha;
    if (h_rdy_r) begin
      unique case (mode_r)
        MODE_RED:   r_o = h_bsat_r[0];
        MODE_GREEN: g_o = h_bsat_r[0];
        MODE_BLUE:  b_o = h_bsat_r[0];
        MODE_ALPHA: a_o = h_bsat_r[0];
        MODE_LUMA: begin
          r_o = h_lres_r[0];
          g_o = h_lres_r[1];
          b_o = h_lres_r[2];
        end
        MODE_RGB: begin
          r_o = h_bsat_r[0];
          g_o = h_bsat_r[1];
          b_o = h_bsat_r[2];
        end
        MODE_HUE: begin
          // grey pixels keep their color
          if (!h_d_r.grey) begin
            r_o = hr;
            g_o = hg;
            b_o = hb;
          end
        end
        MODE_SAT: begin
          r_o = hr;
          g_o = hg;
          b_o = hb;
        end
        default: ;
      endcase
    end
    out_data_nxt = {a_o, b_o, g_o, r_o};
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= h_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

>>> src/pcl_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module pcl_ram #(
  parameter  int WIDTH = 16,
  parameter  int DEPTH = 512,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> src/pcl_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Pipelined restoring divider, DIV_STEP quotient bits per stage.
module pcl_div (
  input  wire logic                             clk,
  input  wire logic                             en,
  input  wire logic [pcl_pkg::DIV_NUM_W-1:0]    num,
  input  wire logic [pcl_pkg::DIV_DEN_W-1:0]    den,
  output logic      [pcl_pkg::DIV_NUM_W-1:0]    quo
);
  import pcl_pkg::*;

  logic [DIV_NUM_W-1:0] num_r [DIV_STAGES];
  logic [DIV_NUM_W-1:0] quo_r [DIV_STAGES];
  logic [DIV_DEN_W-1:0] rem_r [DIV_STAGES];
  logic [DIV_DEN_W-1:0] den_r [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [DIV_NUM_W-1:0] num_in, quo_in, num_nxt, quo_nxt;
    logic [DIV_DEN_W-1:0] rem_in, den_in, rem_nxt;

    if (k == 0) begin : g_first
      assign num_in = num;
      assign quo_in = '0;
      assign rem_in = '0;
      assign den_in = den;
    end else begin : g_next
      assign num_in = num_r[k-1];
      assign quo_in = quo_r[k-1];
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
    end

    always_comb begin
      logic [DIV_DEN_W:0] trial;
      num_nxt = num_in;
      quo_nxt = quo_in;
      rem_nxt = rem_in;
      for (int i = 0; i < DIV_STEP; i++) begin
        trial   = {rem_nxt, num_nxt[DIV_NUM_W-1]};
        num_nxt = num_nxt << 1;
        if (trial >= {1'b0, den_in}) begin
          rem_nxt = DIV_DEN_W'(trial - {1'b0, den_in});
          quo_nxt = {quo_nxt[DIV_NUM_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial[DIV_DEN_W-1:0];
          quo_nxt = {quo_nxt[DIV_NUM_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num_r[k] <= num_nxt;
        quo_r[k] <= quo_nxt;
        rem_r[k] <= rem_nxt;
        den_r[k] <= den_in;
      end
    end
  end

  assign quo = quo_r[DIV_STAGES-1];

endmodule

`default_nettype wire

>>> src/pcl_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module pcl_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_tvalid,
  input wire logic                              in_tready,
  input wire logic [pcl_pkg::IN_TDATA_W-1:0]    in_tdata,
  input wire logic [pcl_pkg::IN_TUSER_W-1:0]    in_tuser,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [pcl_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");

  // Hold a stalled input transaction
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata) && $stable(in_tuser))
    else $error("stalled input changed or dropped");

  // Backpressure only while a result waits at the output
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output stage");

  // Drop all results on reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result shown after reset");

  // No result may appear straight after reset
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result shown in the first cycle after reset");

endmodule

bind pixel_curve_lut_mapper pcl_checker u_pcl_checker (.*);

`default_nettype wire
